// ===== rtl/core/e2q_pkg.sv =====
// Shared types, constants and fixed-point helpers for the Euler angle to quaternion converter.
package e2q_pkg;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } e2q_in_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } e2q_out_t;

  localparam logic signed [15:0] ANG_LIMIT   = 16'sd25736;
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [32:0] ONE_Q30     = 33'sd1073741824;
  localparam logic [31:0]        Q_MAX       = 32'd16384;

  localparam int STEPS     = 6;
  localparam int SIN_STEPS = 5;
  localparam int COS_DIV [STEPS]     = '{132, 90, 56, 30, 12, 2};
  localparam int SIN_DIV [SIN_STEPS] = '{110, 72, 42, 20, 6};

  localparam int SC_LAT  = 2 + 4 * STEPS;
  localparam int MAT_LAT = 6;
  localparam int ISQ_LAT = 9;
  localparam int LAT     = SC_LAT + MAT_LAT + ISQ_LAT;

  function automatic logic signed [35:0] trunc_q30(input logic signed [65:0] p);
    logic signed [65:0] b;
    b = p[65] ? p + 66'sd1073741823 : p;
    b = b >>> 30;
    return $signed(b[35:0]);
  endfunction

  function automatic logic signed [31:0] mulq_trunc(input logic signed [65:0] p);
    logic signed [35:0] t;
    t = trunc_q30(p);
    return $signed(t[31:0]);
  endfunction

endpackage

// ===== rtl/core/euler_to_quaternion.sv =====
// Euler angle (roll, pitch, yaw) to unit quaternion converter, fully pipelined.
// An accepted beat passes in order through the series sine and cosine lanes, the rotation
// matrix stages, and the square root stages to its result.
// Throughput is one beat per cycle; a stalled output freezes the whole pipeline in place.
// Synchronous active-low reset clears only the valid bits of the stages.
module euler_to_quaternion (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  e2q_pkg::e2q_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output e2q_pkg::e2q_out_t out_data
);

  localparam int LAT = e2q_pkg::LAT;

  logic           en;
  logic [LAT-1:0] vld_r;

  assign en        = !(vld_r[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  logic signed [31:0] sphi, cphi, sth, cth, sps, cps;

  e2q_sincos u_roll (
    .clk(clk), .en(en), .angle(in_data.roll_angle), .sin_o(sphi), .cos_o(cphi)
  );
  e2q_sincos u_pitch (
    .clk(clk), .en(en), .angle(in_data.pitch_angle), .sin_o(sth), .cos_o(cth)
  );
  e2q_sincos u_yaw (
    .clk(clk), .en(en), .angle(in_data.yaw_angle), .sin_o(sps), .cos_o(cps)
  );

  logic signed [63:0] p00_r, pcs_r, pss_r, p10_r, pcc_r, pcsp_r, pscp_r, pssp_r, p21_r, p22_r;
  logic signed [31:0] sphi1_r, cphi1_r, sth1_r;
  logic signed [31:0] r00_2_r, mcs_2_r, mss_2_r, r10_2_r, cc_2_r, csp_2_r, scp_2_r, ssp_2_r;
  logic signed [31:0] r21_2_r, r22_2_r, sphi2_r, cphi2_r, sth2_r;
  logic signed [63:0] a01p_r, a02p_r, a11p_r, a12p_r;
  logic signed [31:0] r00_3_r, r10_3_r, cc_3_r, csp_3_r, scp_3_r, ssp_3_r;
  logic signed [31:0] r21_3_r, r22_3_r, sth3_r;
  logic signed [31:0] a01_r, a02_r, a11_r, a12_r;
  logic signed [31:0] r00_4_r, r10_4_r, cc_4_r, csp_4_r, scp_4_r, ssp_4_r;
  logic signed [31:0] r21_4_r, r22_4_r, sth4_r;
  logic signed [32:0] r01_r, r02_r, r11_r, r12_r, r20_r;
  logic signed [31:0] r00_5_r, r10_5_r, r21_5_r, r22_5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r   <= cps * cth;
      pcs_r   <= cps * sth;
      pss_r   <= sps * sth;
      p10_r   <= sps * cth;
      pcc_r   <= cps * cphi;
      pcsp_r  <= cps * sphi;
      pscp_r  <= sps * cphi;
      pssp_r  <= sps * sphi;
      p21_r   <= cth * sphi;
      p22_r   <= cth * cphi;
      sphi1_r <= sphi;
      cphi1_r <= cphi;
      sth1_r  <= sth;

      r00_2_r <= e2q_pkg::mulq_trunc(p00_r);
      mcs_2_r <= e2q_pkg::mulq_trunc(pcs_r);
      mss_2_r <= e2q_pkg::mulq_trunc(pss_r);
      r10_2_r <= e2q_pkg::mulq_trunc(p10_r);
      cc_2_r  <= e2q_pkg::mulq_trunc(pcc_r);
      csp_2_r <= e2q_pkg::mulq_trunc(pcsp_r);
      scp_2_r <= e2q_pkg::mulq_trunc(pscp_r);
      ssp_2_r <= e2q_pkg::mulq_trunc(pssp_r);
      r21_2_r <= e2q_pkg::mulq_trunc(p21_r);
      r22_2_r <= e2q_pkg::mulq_trunc(p22_r);
      sphi2_r <= sphi1_r;
      cphi2_r <= cphi1_r;
      sth2_r  <= sth1_r;

      a01p_r  <= mcs_2_r * sphi2_r;
      a02p_r  <= mcs_2_r * cphi2_r;
      a11p_r  <= mss_2_r * sphi2_r;
      a12p_r  <= mss_2_r * cphi2_r;
      r00_3_r <= r00_2_r;
      r10_3_r <= r10_2_r;
      cc_3_r  <= cc_2_r;
      csp_3_r <= csp_2_r;
      scp_3_r <= scp_2_r;
      ssp_3_r <= ssp_2_r;
      r21_3_r <= r21_2_r;
      r22_3_r <= r22_2_r;
      sth3_r  <= sth2_r;

      a01_r   <= e2q_pkg::mulq_trunc(a01p_r);
      a02_r   <= e2q_pkg::mulq_trunc(a02p_r);
      a11_r   <= e2q_pkg::mulq_trunc(a11p_r);
      a12_r   <= e2q_pkg::mulq_trunc(a12p_r);
      r00_4_r <= r00_3_r;
      r10_4_r <= r10_3_r;
      cc_4_r  <= cc_3_r;
      csp_4_r <= csp_3_r;
      scp_4_r <= scp_3_r;
      ssp_4_r <= ssp_3_r;
      r21_4_r <= r21_3_r;
      r22_4_r <= r22_3_r;
      sth4_r  <= sth3_r;

      r01_r   <= 33'(a01_r) - 33'(scp_4_r);
      r02_r   <= 33'(a02_r) + 33'(ssp_4_r);
      r11_r   <= 33'(a11_r) + 33'(cc_4_r);
      r12_r   <= 33'(a12_r) - 33'(csp_4_r);
      r20_r   <= -33'(sth4_r);
      r00_5_r <= r00_4_r;
      r10_5_r <= r10_4_r;
      r21_5_r <= r21_4_r;
      r22_5_r <= r22_4_r;
    end
  end

  logic signed [35:0] sw_w, sx_w, sy_w, sz_w;
  logic signed [33:0] dx_w, dy_w, dz_w;
  logic [31:0]        vw_r, vx_r, vy_r, vz_r;
  logic               nx_r, ny_r, nz_r;

  always_comb begin
    sw_w = e2q_pkg::ONE_Q30 + r00_5_r + r11_r + r22_5_r;
    sx_w = e2q_pkg::ONE_Q30 + r00_5_r - r11_r - r22_5_r;
    sy_w = e2q_pkg::ONE_Q30 - r00_5_r + r11_r - r22_5_r;
    sz_w = e2q_pkg::ONE_Q30 - r00_5_r - r11_r + r22_5_r;
    dx_w = r21_5_r - r12_r;
    dy_w = r02_r - r20_r;
    dz_w = r10_5_r - r01_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vw_r <= sw_w[35] ? '0 : sw_w[35:4];
      vx_r <= sx_w[35] ? '0 : sx_w[35:4];
      vy_r <= sy_w[35] ? '0 : sy_w[35:4];
      vz_r <= sz_w[35] ? '0 : sz_w[35:4];
      nx_r <= dx_w[33];
      ny_r <= dy_w[33];
      nz_r <= dz_w[33];
    end
  end

  logic signed [15:0] qw, qx, qy, qz;

  e2q_isqrt u_sq_w (.clk(clk), .en(en), .val(vw_r), .neg(1'b0), .root(qw));
  e2q_isqrt u_sq_x (.clk(clk), .en(en), .val(vx_r), .neg(nx_r), .root(qx));
  e2q_isqrt u_sq_y (.clk(clk), .en(en), .val(vy_r), .neg(ny_r), .root(qy));
  e2q_isqrt u_sq_z (.clk(clk), .en(en), .val(vz_r), .neg(nz_r), .root(qz));

  always_comb begin
    out_data.quat_w = qw;
    out_data.quat_x = qx;
    out_data.quat_y = qy;
    out_data.quat_z = qz;
  end

endmodule

// ===== rtl/core/e2q_sincos.sv =====
// Pipelined sine and cosine of one angle by truncating Taylor series steps.
module e2q_sincos (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] angle,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  logic signed [15:0] sat_w;
  logic signed [33:0] a_w;
  logic signed [33:0] r_w;
  logic               nc_w;
  logic signed [31:0] r0_r;
  logic               nc0_r;
  logic signed [63:0] sq_w;
  logic [31:0]        x2_r;
  logic signed [31:0] r1_r;
  logic               nc1_r;

  always_comb begin
    if (angle > e2q_pkg::ANG_LIMIT) begin
      sat_w = e2q_pkg::ANG_LIMIT;
    end else if (angle < -e2q_pkg::ANG_LIMIT) begin
      sat_w = -e2q_pkg::ANG_LIMIT;
    end else begin
      sat_w = angle;
    end
    a_w  = $signed({sat_w[15], sat_w, 17'd0});
    r_w  = a_w;
    nc_w = 1'b0;
    if (a_w > e2q_pkg::HALF_PI_Q30) begin
      r_w  = e2q_pkg::PI_Q30 - a_w;
      nc_w = 1'b1;
    end else if (a_w < -e2q_pkg::HALF_PI_Q30) begin
      r_w  = -e2q_pkg::PI_Q30 - a_w;
      nc_w = 1'b1;
    end
  end

  assign sq_w = r0_r * r0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r0_r  <= $signed(r_w[31:0]);
      nc0_r <= nc_w;
      x2_r  <= sq_w[61:30];
      r1_r  <= r0_r;
      nc1_r <= nc0_r;
    end
  end

  logic [31:0]        x2_s [e2q_pkg::STEPS];
  logic signed [31:0] r_s  [e2q_pkg::STEPS];
  logic               nc_s [e2q_pkg::STEPS];
  logic signed [32:0] tc_s [e2q_pkg::STEPS+1];
  logic signed [32:0] ts_s [e2q_pkg::STEPS+1];

  assign x2_s[0] = x2_r;
  assign r_s[0]  = r1_r;
  assign nc_s[0] = nc1_r;
  assign tc_s[0] = e2q_pkg::ONE_Q30;
  assign ts_s[0] = e2q_pkg::ONE_Q30;

  for (genvar i = 0; i < e2q_pkg::STEPS; i++) begin : g_step
    localparam logic [7:0]  DC   = 8'(e2q_pkg::COS_DIV[i]);
    localparam logic [31:0] MC   = 32'((64'd1 << 32) / e2q_pkg::COS_DIV[i]);
    localparam bit          LAST = (i == e2q_pkg::STEPS - 1);

    logic signed [32:0] sop_w;
    logic signed [65:0] pc_r;
    logic signed [65:0] ps_r;
    logic               nca_r, ncb_r, ncc_r;
    logic signed [35:0] tpc_w, tps_w;
    logic [31:0]        mcb_r, mcc_r, msb_r, msc_r;
    logic               ngcb_r, ngcc_r, ngsb_r, ngsc_r;
    logic [63:0]        qc_r;
    logic [31:0]        q0c_w, qc_w;
    logic [39:0]        remc_w;
    logic signed [32:0] tnc_w;
    logic signed [32:0] tc_r;

    assign sop_w = LAST ? $signed({r_s[i][31], r_s[i]}) : $signed({1'b0, x2_s[i]});

    always_comb begin
      tpc_w  = e2q_pkg::trunc_q30(pc_r);
      tps_w  = e2q_pkg::trunc_q30(ps_r);
      q0c_w  = qc_r[63:32];
      remc_w = {8'd0, mcc_r} - 40'(q0c_w) * 40'(DC);
      qc_w   = q0c_w + 32'(remc_w >= 40'(DC));
      tnc_w  = ngcc_r ? e2q_pkg::ONE_Q30 + $signed({1'b0, qc_w})
                      : e2q_pkg::ONE_Q30 - $signed({1'b0, qc_w});
      if (LAST && ncc_r) begin
        tnc_w = -tnc_w;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pc_r   <= $signed({1'b0, x2_s[i]}) * tc_s[i];
        ps_r   <= sop_w * ts_s[i];
        nca_r  <= nc_s[i];
        ngcb_r <= tpc_w[35];
        mcb_r  <= tpc_w[35] ? 32'(-tpc_w) : tpc_w[31:0];
        ngsb_r <= tps_w[35];
        msb_r  <= tps_w[35] ? 32'(-tps_w) : tps_w[31:0];
        ncb_r  <= nca_r;
        qc_r   <= 64'(mcb_r) * 64'(MC);
        mcc_r  <= mcb_r;
        ngcc_r <= ngcb_r;
        msc_r  <= msb_r;
        ngsc_r <= ngsb_r;
        ncc_r  <= ncb_r;
        tc_r   <= tnc_w;
      end
    end

    assign tc_s[i+1] = tc_r;

    if (i < e2q_pkg::SIN_STEPS) begin : g_sdiv
      localparam logic [7:0]  DS = 8'(e2q_pkg::SIN_DIV[i]);
      localparam logic [31:0] MS = 32'((64'd1 << 32) / e2q_pkg::SIN_DIV[i]);
      logic [63:0]        qs_r;
      logic [31:0]        q0s_w, qs_w;
      logic [39:0]        rems_w;
      logic signed [32:0] ts_r;

      always_comb begin
        q0s_w  = qs_r[63:32];
        rems_w = {8'd0, msc_r} - 40'(q0s_w) * 40'(DS);
        qs_w   = q0s_w + 32'(rems_w >= 40'(DS));
      end

      always_ff @(posedge clk) begin
        if (en) begin
          qs_r <= 64'(msb_r) * 64'(MS);
          ts_r <= ngsc_r ? e2q_pkg::ONE_Q30 + $signed({1'b0, qs_w})
                         : e2q_pkg::ONE_Q30 - $signed({1'b0, qs_w});
        end
      end

      assign ts_s[i+1] = ts_r;
    end else begin : g_sfin
      logic signed [32:0] ts_r;

      always_ff @(posedge clk) begin
        if (en) begin
          ts_r <= ngsc_r ? -$signed({1'b0, msc_r}) : $signed({1'b0, msc_r});
        end
      end

      assign ts_s[i+1] = ts_r;
    end

    if (!LAST) begin : g_pass
      logic [31:0]        x2a_r, x2b_r, x2c_r, x2d_r;
      logic signed [31:0] ra_r, rb_r, rc_r, rd_r;
      logic               ncd_r;

      always_ff @(posedge clk) begin
        if (en) begin
          x2a_r <= x2_s[i];
          x2b_r <= x2a_r;
          x2c_r <= x2b_r;
          x2d_r <= x2c_r;
          ra_r  <= r_s[i];
          rb_r  <= ra_r;
          rc_r  <= rb_r;
          rd_r  <= rc_r;
          ncd_r <= ncc_r;
        end
      end

      assign x2_s[i+1] = x2d_r;
      assign r_s[i+1]  = rd_r;
      assign nc_s[i+1] = ncd_r;
    end
  end

  assign sin_o = $signed(ts_s[e2q_pkg::STEPS][31:0]);
  assign cos_o = $signed(tc_s[e2q_pkg::STEPS][31:0]);

endmodule

// ===== rtl/core/e2q_isqrt.sv =====
// Pipelined rounded integer square root with cap and sign for one quaternion component.
module e2q_isqrt (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        val,
  input  logic               neg,
  output logic signed [15:0] root
);

  localparam int PAIRS = 8;

  logic [31:0] n_s   [PAIRS+1];
  logic [31:0] res_s [PAIRS+1];
  logic        ng_s  [PAIRS+1];

  assign n_s[0]   = val;
  assign res_s[0] = '0;
  assign ng_s[0]  = neg;

  for (genvar g = 0; g < PAIRS; g++) begin : g_pair
    localparam int K0 = 2 * (PAIRS - 1 - g) + 1;
    logic [31:0] nw, rw;
    logic [31:0] n_r, res_r;
    logic        ng_r;

    always_comb begin
      logic [31:0] bitv;
      nw = n_s[g];
      rw = res_s[g];
      for (int j = 0; j < 2; j++) begin
        bitv = 32'd1 << (2 * (K0 - j));
        if (nw >= rw + bitv) begin
          nw = nw - (rw + bitv);
          rw = (rw >> 1) + bitv;
        end else begin
          rw = rw >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r   <= nw;
        res_r <= rw;
        ng_r  <= ng_s[g];
      end
    end

    assign n_s[g+1]   = n_r;
    assign res_s[g+1] = res_r;
    assign ng_s[g+1]  = ng_r;
  end

  logic [31:0]        rr_w;
  logic [15:0]        mag_w;
  logic signed [15:0] root_nxt;
  logic signed [15:0] root_r;

  always_comb begin
    rr_w     = res_s[PAIRS] + 32'(n_s[PAIRS] > res_s[PAIRS]);
    mag_w    = (rr_w > e2q_pkg::Q_MAX) ? e2q_pkg::Q_MAX[15:0] : rr_w[15:0];
    root_nxt = ng_s[PAIRS] ? -$signed(mag_w) : $signed(mag_w);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_r <= root_nxt;
    end
  end

  assign root = root_r;

endmodule

// ===== rtl/core/e2q_checker.sv =====
// Port-level checker for the Euler angle to quaternion converter, bound to the top level.
module e2q_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input e2q_pkg::e2q_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input e2q_pkg::e2q_out_t out_data
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result beat valid right after reset.");

  a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("Input stalled while the output was free.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("Stalled result beat changed or dropped.");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_data)))
    else $error("Stalled input beat changed or withdrawn.");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.quat_w <= 16'sd16384) && (out_data.quat_w >= 16'sd0)
               && (out_data.quat_x <= 16'sd16384) && (out_data.quat_x >= -16'sd16384)
               && (out_data.quat_y <= 16'sd16384) && (out_data.quat_y >= -16'sd16384)
               && (out_data.quat_z <= 16'sd16384) && (out_data.quat_z >= -16'sd16384))
    else $error("Quaternion component out of range.");

endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the Euler angle to quaternion converter with a fixed-point predictor.
`timescale 1ns / 1ps

module tb;

  localparam int      PIPE_DEPTH  = 41;
  localparam int      RANDOM_BEATS = 750;
  localparam longint  Q30_ONE     = 64'sd1073741824;
  localparam longint  Q30_PI      = 64'sd3373259426;
  localparam longint  Q30_HALF_PI = 64'sd1686629713;
  localparam longint  ANGLE_BOUND = 25736;
  localparam longint  QUAT_CAP    = 16384;

  typedef struct {
    e2q_pkg::e2q_in_t  angles;
    logic              known;
    e2q_pkg::e2q_out_t quat;
  } vector_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  e2q_pkg::e2q_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  e2q_pkg::e2q_out_t out_data;

  e2q_pkg::e2q_out_t expected_quats[$];
  int                error_count;
  logic              driving_done;
  logic              hold_off_done;
  vector_t           directed_vectors[$];

  euler_to_quaternion DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("** euler_to_quaternion: FAILED **");
    $finish;
  end

  function automatic longint q30_mul(longint a, longint b);
    return (a * b) / Q30_ONE;
  endfunction

  function automatic longint widen_angle(logic signed [15:0] raw);
    longint v;
    v = raw;
    if (v > ANGLE_BOUND) v = ANGLE_BOUND;
    if (v < -ANGLE_BOUND) v = -ANGLE_BOUND;
    return v * 131072;
  endfunction

  function automatic void sin_cos(input longint a, output longint s, output longint c);
    longint r;
    longint sq;
    longint t;
    logic   flip;
    longint sdiv[5];
    longint cdiv[6];
    sdiv = '{110, 72, 42, 20, 6};
    cdiv = '{132, 90, 56, 30, 12, 2};
    r = a;
    flip = 1'b0;
    if (a > Q30_HALF_PI) begin
      r = Q30_PI - a;
      flip = 1'b1;
    end else if (a < -Q30_HALF_PI) begin
      r = -Q30_PI - a;
      flip = 1'b1;
    end
    sq = q30_mul(r, r);
    t = Q30_ONE;
    for (int i = 0; i < 5; i++) t = Q30_ONE - q30_mul(sq, t) / sdiv[i];
    s = q30_mul(r, t);
    t = Q30_ONE;
    for (int i = 0; i < 6; i++) t = Q30_ONE - q30_mul(sq, t) / cdiv[i];
    c = flip ? -t : t;
  endfunction

  function automatic longint rounded_half_root(longint s);
    longint unsigned v;
    longint unsigned root;
    if (s < 0) s = 0;
    v = s / 16;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((root | (64'd1 << b)) * (root | (64'd1 << b)) <= v) root = root | (64'd1 << b);
    end
    if (v - root * root > root) root++;
    if (root > QUAT_CAP) root = QUAT_CAP;
    return longint'(root);
  endfunction

  function automatic e2q_pkg::e2q_out_t angles_to_quat(e2q_pkg::e2q_in_t a);
    longint sr, cr, sp, cp, sy, cy;
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
    longint qw, qx, qy, qz;
    e2q_pkg::e2q_out_t q;
    sin_cos(widen_angle(a.roll_angle), sr, cr);
    sin_cos(widen_angle(a.pitch_angle), sp, cp);
    sin_cos(widen_angle(a.yaw_angle), sy, cy);
    m00 = q30_mul(cy, cp);
    m01 = q30_mul(q30_mul(cy, sp), sr) - q30_mul(sy, cr);
    m02 = q30_mul(q30_mul(cy, sp), cr) + q30_mul(sy, sr);
    m10 = q30_mul(sy, cp);
    m11 = q30_mul(q30_mul(sy, sp), sr) + q30_mul(cy, cr);
    m12 = q30_mul(q30_mul(sy, sp), cr) - q30_mul(cy, sr);
    m20 = -sp;
    m21 = q30_mul(cp, sr);
    m22 = q30_mul(cp, cr);
    qw = rounded_half_root(Q30_ONE + m00 + m11 + m22);
    qx = rounded_half_root(Q30_ONE + m00 - m11 - m22);
    qy = rounded_half_root(Q30_ONE - m00 + m11 - m22);
    qz = rounded_half_root(Q30_ONE - m00 - m11 + m22);
    if (m21 - m12 < 0) qx = -qx;
    if (m02 - m20 < 0) qy = -qy;
    if (m10 - m01 < 0) qz = -qz;
    q.quat_w = qw[15:0];
    q.quat_x = qx[15:0];
    q.quat_y = qy[15:0];
    q.quat_z = qz[15:0];
    return q;
  endfunction

  function automatic logic signed [15:0] random_angle();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'($urandom);
    if (pick == 1) return $urandom_range(0, 1) ? 16'sd25736 : -16'sd25736;
    if (pick == 2) return 16'($signed($urandom_range(0, 200)) - 100);
    if (pick == 3) return 16'($signed($urandom_range(0, 400)) + 12668 * ($urandom_range(0, 1) ? 1 : -1));
    return 16'($signed($urandom_range(0, 51472)) - 25736);
  endfunction

  task automatic add_vector(int r, int p, int y, logic known, int w, int x, int yq, int z);
    vector_t v;
    v.angles.roll_angle = 16'(r);
    v.angles.pitch_angle = 16'(p);
    v.angles.yaw_angle = 16'(y);
    v.known = known;
    v.quat.quat_w = 16'(w);
    v.quat.quat_x = 16'(x);
    v.quat.quat_y = 16'(yq);
    v.quat.quat_z = 16'(z);
    directed_vectors = {directed_vectors, v};
  endtask

  task automatic send_beat(e2q_pkg::e2q_in_t angles, logic known, e2q_pkg::e2q_out_t quat);
    e2q_pkg::e2q_out_t want;
    in_data <= angles;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = known ? quat : angles_to_quat(angles);
    expected_quats = {expected_quats, want};
  endtask

  task automatic maybe_gap();
    if ($urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  initial begin
    e2q_pkg::e2q_in_t a;
    e2q_pkg::e2q_out_t unused;
    int burst;
    int sent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    driving_done = 1'b0;
    unused = '0;
    add_vector(0, 0, 0, 1'b1, 16384, 0, 0, 0);
    add_vector(25736, 25736, 25736, 1'b0, 0, 0, 0, 0);
    add_vector(-25736, -25736, -25736, 1'b0, 0, 0, 0, 0);
    add_vector(32767, 0, 0, 1'b0, 0, 0, 0, 0);
    add_vector(-32768, 0, 0, 1'b0, 0, 0, 0, 0);
    add_vector(0, 32767, 0, 1'b0, 0, 0, 0, 0);
    add_vector(0, -32768, 0, 1'b0, 0, 0, 0, 0);
    add_vector(0, 0, 32767, 1'b0, 0, 0, 0, 0);
    add_vector(0, 0, -32768, 1'b0, 0, 0, 0, 0);
    add_vector(12868, 0, 0, 1'b0, 0, 0, 0, 0);
    add_vector(-12868, 0, 0, 1'b0, 0, 0, 0, 0);
    add_vector(12869, 12869, 12869, 1'b0, 0, 0, 0, 0);
    add_vector(0, 12868, 0, 1'b0, 0, 0, 0, 0);
    add_vector(0, 0, -12869, 1'b0, 0, 0, 0, 0);
    add_vector(25000, -25000, 25000, 1'b0, 0, 0, 0, 0);
    add_vector(-1, 1, -1, 1'b0, 0, 0, 0, 0);
    add_vector(21845, -21846, 0, 1'b0, 0, 0, 0, 0);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_vectors[i]) begin
      send_beat(directed_vectors[i].angles, directed_vectors[i].known, directed_vectors[i].quat);
      maybe_gap();
    end
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && sent < RANDOM_BEATS; k++) begin
        a.roll_angle = random_angle();
        a.pitch_angle = random_angle();
        a.yaw_angle = random_angle();
        send_beat(a, 1'b0, unused);
        sent++;
      end
      in_valid <= 1'b0;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(posedge clk);
      else @(posedge clk);
    end
    in_valid <= 1'b0;
    driving_done <= 1'b1;
  end

  initial begin
    out_stall = 1'b1;
    hold_off_done = 1'b0;
    @(posedge clk iff rst_n);
    out_stall <= 1'b0;
    repeat (300) @(posedge clk);
    out_stall <= 1'b1;
    repeat (150) @(posedge clk);
    hold_off_done <= 1'b1;
    forever begin
      case ($urandom_range(0, 3))
        0: out_stall <= 1'b0;
        1: out_stall <= $urandom_range(0, 1);
        2: out_stall <= ($urandom_range(0, 4) == 0);
        default: out_stall <= ($urandom_range(0, 4) != 0);
      endcase
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    e2q_pkg::e2q_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_quats.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, out_data);
        error_count++;
      end else begin
        want = expected_quats.pop_front();
        if (out_data.quat_w !== want.quat_w) begin
          $display("%0t: quat_w expected %0d got %0d", $time, want.quat_w, out_data.quat_w);
          error_count++;
        end
        if (out_data.quat_x !== want.quat_x) begin
          $display("%0t: quat_x expected %0d got %0d", $time, want.quat_x, out_data.quat_x);
          error_count++;
        end
        if (out_data.quat_y !== want.quat_y) begin
          $display("%0t: quat_y expected %0d got %0d", $time, want.quat_y, out_data.quat_y);
          error_count++;
        end
        if (out_data.quat_z !== want.quat_z) begin
          $display("%0t: quat_z expected %0d got %0d", $time, want.quat_z, out_data.quat_z);
          error_count++;
        end
      end
    end
  end

  initial begin
    int waited;
    error_count = 0;
    wait (driving_done && hold_off_done);
    waited = 0;
    while (expected_quats.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (error_count == 0 && expected_quats.size() == 0) begin
      $display("** euler_to_quaternion: PASSED **");
    end else begin
      $display("** euler_to_quaternion: FAILED **");
    end
    $finish;
  end

endmodule
